[rtl/rsd_pkg.sv]
// Shared types for the rectangle symmetric difference block.
`default_nettype none

package rsd_pkg;

    localparam int CoordW = 16;
    localparam int SizeW  = 15;
    localparam int Cells  = 9;

    typedef logic [CoordW-1:0] t_coord;
    typedef logic [Cells-1:0]  t_mask;

    // Grid lines and the cells to emit for one word.
    typedef struct packed {
        t_coord [3:0] gx;
        t_coord [3:0] gy;
        t_mask        mask;
    } t_plan;

    localparam t_mask MaskPassThrough = 9'b1_0000_0001;

endpackage

`default_nettype wire

[rtl/rect_symmetric_difference.sv]
// Top level of the rectangle symmetric difference block.
//
// Input channel: i_valid / o_stall carry one word holding two rectangles
// (A: i_ax, i_ay, i_aw, i_ah; B: i_bx, i_by, i_bw, i_bh). A word is taken
// on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry result rectangles, one per word
// moved, o_is_last set on the final rectangle of each input word. A pair
// yields 0 to 8 rectangles; a pair with none yields no output word.
// The first rectangle of a pair passes the input register, plan register
// and result register; the rest follow one per cycle while i_stall is low.
// The emit stage emits one rectangle per cycle while not stalled, and the
// next pair's plan loads in the same cycle as the last rectangle of the
// current pair is taken, so a new pair can enter before that one has left.
// When the receiver stalls, the current rectangle holds and the input
// register, plan register and result register fill, then o_stall rises.
// Reset (synchronous, active low) drops all pending work.
`default_nettype none

module rect_symmetric_difference (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [14:0] i_ax,
    input  logic signed [14:0] i_ay,
    input  logic        [13:0] i_aw,
    input  logic        [13:0] i_ah,
    input  logic signed [14:0] i_bx,
    input  logic signed [14:0] i_by,
    input  logic        [13:0] i_bw,
    input  logic        [13:0] i_bh,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic        [14:0] o_out_w,
    output logic        [14:0] o_out_h,
    output logic               o_is_last
);

    logic               r_in_valid, n_in_valid;
    logic signed [14:0] r_ax, r_ay, r_bx, r_by;
    logic        [13:0] r_aw, r_ah, r_bw, r_bh;
    logic               accept, plan_free;
    rsd_pkg::t_plan     plan;

    assign o_stall = r_in_valid && !plan_free;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (plan_free) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        if (accept) begin
            r_ax <= i_ax;
            r_ay <= i_ay;
            r_aw <= i_aw;
            r_ah <= i_ah;
            r_bx <= i_bx;
            r_by <= i_by;
            r_bw <= i_bw;
            r_bh <= i_bh;
        end
    end

    rsd_grid u_grid (
        .i_ax   (r_ax),
        .i_ay   (r_ay),
        .i_aw   (r_aw),
        .i_ah   (r_ah),
        .i_bx   (r_bx),
        .i_by   (r_by),
        .i_bw   (r_bw),
        .i_bh   (r_bh),
        .o_plan (plan)
    );

    rsd_burst u_burst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_plan_valid (r_in_valid),
        .i_plan       (plan),
        .o_plan_free  (plan_free),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_w      (o_out_w),
        .o_out_h      (o_out_h),
        .o_is_last    (o_is_last)
    );

endmodule

`default_nettype wire

[rtl/rsd_grid.sv]
// Edge sums, sort, overlap test and cell selection for one rectangle pair.
`default_nettype none

module rsd_grid (
    input  logic signed [14:0] i_ax,
    input  logic signed [14:0] i_ay,
    input  logic        [13:0] i_aw,
    input  logic        [13:0] i_ah,
    input  logic signed [14:0] i_bx,
    input  logic signed [14:0] i_by,
    input  logic        [13:0] i_bw,
    input  logic        [13:0] i_bh,
    output rsd_pkg::t_plan     o_plan
);

    logic signed [15:0] ax, ay, ar, ab, bx, by, br, bb;
    logic signed [15:0] gx [4];
    logic signed [15:0] gy [4];
    logic [2:0] col_a, col_b, row_a, row_b, col_pos, row_pos;
    logic overlap;
    rsd_pkg::t_mask cell_mask;

    assign ax = 16'(i_ax);
    assign ay = 16'(i_ay);
    assign bx = 16'(i_bx);
    assign by = 16'(i_by);
    assign ar = ax + signed'({2'b00, i_aw});
    assign ab = ay + signed'({2'b00, i_ah});
    assign br = bx + signed'({2'b00, i_bw});
    assign bb = by + signed'({2'b00, i_bh});

    always_comb begin
        gx[0] = (ax < bx) ? ax : bx;
        gx[1] = (ax < bx) ? bx : ax;
        gx[2] = (ar < br) ? ar : br;
        gx[3] = (ar < br) ? br : ar;
        gy[0] = (ay < by) ? ay : by;
        gy[1] = (ay < by) ? by : ay;
        gy[2] = (ab < bb) ? ab : bb;
        gy[3] = (ab < bb) ? bb : ab;
    end

    assign overlap = (gx[1] < gx[2]) && (gy[1] < gy[2]);

    // grid lines include every edge, so a nonempty cell is wholly in or out
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            col_pos[i] = gx[i] < gx[i+1];
            row_pos[i] = gy[i] < gy[i+1];
            col_a[i]   = (ax <= gx[i]) && (gx[i+1] <= ar);
            col_b[i]   = (bx <= gx[i]) && (gx[i+1] <= br);
            row_a[i]   = (ay <= gy[i]) && (gy[i+1] <= ab);
            row_b[i]   = (by <= gy[i]) && (gy[i+1] <= bb);
        end
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                cell_mask[j*3+i] = col_pos[i] && row_pos[j] &&
                                   ((col_a[i] && row_a[j]) != (col_b[i] && row_b[j]));
            end
        end
    end

    // no overlap: A rides in the top-left cell, B in the bottom-right
    always_comb begin
        if (overlap) begin
            for (int k = 0; k < 4; k++) begin
                o_plan.gx[k] = gx[k];
                o_plan.gy[k] = gy[k];
            end
            o_plan.mask = cell_mask;
        end else begin
            o_plan.gx[0] = ax;
            o_plan.gx[1] = ar;
            o_plan.gx[2] = bx;
            o_plan.gx[3] = br;
            o_plan.gy[0] = ay;
            o_plan.gy[1] = ab;
            o_plan.gy[2] = by;
            o_plan.gy[3] = bb;
            o_plan.mask  = rsd_pkg::MaskPassThrough;
        end
    end

endmodule

`default_nettype wire

[rtl/rsd_burst.sv]
// Plan register and result register; emits one selected cell per cycle while the output is not stalled.
`default_nettype none

module rsd_burst (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_plan_valid,
    input  rsd_pkg::t_plan       i_plan,
    output logic                 o_plan_free,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [15:0]   o_out_x,
    output logic signed [15:0]   o_out_y,
    output logic        [14:0]   o_out_w,
    output logic        [14:0]   o_out_h,
    output logic                 o_is_last
);

    rsd_pkg::t_coord [3:0] r_gx, n_gx, r_gy, n_gy;
    rsd_pkg::t_mask        r_mask, n_mask;
    logic                  r_out_valid, n_out_valid;
    logic [15:0]           r_x, n_x, r_y, n_y;
    logic [14:0]           r_w, n_w, r_h, n_h;
    logic                  r_last, n_last;

    rsd_pkg::t_mask low, rem;
    logic [2:0]     csel, rsel;
    rsd_pkg::t_coord x_lo, x_hi, y_lo, y_hi;
    logic [15:0]    w_diff, h_diff;
    logic           take, load;

    assign rem  = r_mask & (r_mask - 9'd1);
    assign low  = r_mask & ~(r_mask - 9'd1);
    assign csel = {low[2] | low[5] | low[8], low[1] | low[4] | low[7], low[0] | low[3] | low[6]};
    assign rsel = {|low[8:6], |low[5:3], |low[2:0]};

    always_comb begin
        x_lo = csel[0] ? r_gx[0] : (csel[1] ? r_gx[1] : r_gx[2]);
        x_hi = csel[0] ? r_gx[1] : (csel[1] ? r_gx[2] : r_gx[3]);
        y_lo = rsel[0] ? r_gy[0] : (rsel[1] ? r_gy[1] : r_gy[2]);
        y_hi = rsel[0] ? r_gy[1] : (rsel[1] ? r_gy[2] : r_gy[3]);
    end

    assign w_diff = x_hi - x_lo;
    assign h_diff = y_hi - y_lo;

    assign take        = (r_mask != '0) && (!r_out_valid || !i_stall);
    assign o_plan_free = (r_mask == '0) || (take && (rem == '0));
    assign load        = i_plan_valid && o_plan_free;

    always_comb begin
        n_gx        = r_gx;
        n_gy        = r_gy;
        n_mask      = r_mask;
        n_out_valid = r_out_valid;
        n_x         = r_x;
        n_y         = r_y;
        n_w         = r_w;
        n_h         = r_h;
        n_last      = r_last;
        if (take) begin
            n_mask = rem;
        end
        if (load) begin
            n_gx   = i_plan.gx;
            n_gy   = i_plan.gy;
            n_mask = i_plan.mask;
        end
        if (take) begin
            n_out_valid = 1'b1;
            n_x         = x_lo;
            n_y         = y_lo;
            n_w         = w_diff[14:0];
            n_h         = h_diff[14:0];
            n_last      = (rem == '0);
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
        r_gx   <= n_gx;
        r_gy   <= n_gy;
        r_x    <= n_x;
        r_y    <= n_y;
        r_w    <= n_w;
        r_h    <= n_h;
        r_last <= n_last;
    end

    assign o_valid   = r_out_valid;
    assign o_out_x   = signed'(r_x);
    assign o_out_y   = signed'(r_y);
    assign o_out_w   = r_w;
    assign o_out_h   = r_h;
    assign o_is_last = r_last;

`ifndef SYNTHESIS
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !load) |=> ($countones(r_mask) == $countones($past(r_mask)) - 1))
        else $error("cell mask did not drop exactly one cell");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_out_valid)
        else $error("selected cell not presented");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_mask == '0) && !r_out_valid)
        else $error("reset left work pending");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (rem == '0) && !load) |=> (r_mask == '0))
        else $error("plan not empty after last cell");
`endif

endmodule

`default_nettype wire

[test/rect_symmetric_difference_tb.sv]
// Testbench for rect_symmetric_difference: directed and random pairs against a local predictor.
`timescale 1ns / 100ps

module rect_symmetric_difference_tb;

    localparam int RandomPairs = 370;
    localparam int QuietLimit  = 3000;
    localparam int HoldCycles  = 300;
    localparam int DrainCycles = 16;

    typedef struct {
        logic signed [14:0] ax;
        logic signed [14:0] ay;
        logic        [13:0] aw;
        logic        [13:0] ah;
        logic signed [14:0] bx;
        logic signed [14:0] by;
        logic        [13:0] bw;
        logic        [13:0] bh;
    } t_pair;

    typedef struct {
        logic signed [rsd_pkg::CoordW-1:0] x;
        logic signed [rsd_pkg::CoordW-1:0] y;
        logic        [rsd_pkg::SizeW-1:0]  w;
        logic        [rsd_pkg::SizeW-1:0]  h;
        logic                              last;
    } t_rect;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [14:0] i_ax = '0;
    logic signed [14:0] i_ay = '0;
    logic        [13:0] i_aw = '0;
    logic        [13:0] i_ah = '0;
    logic signed [14:0] i_bx = '0;
    logic signed [14:0] i_by = '0;
    logic        [13:0] i_bw = '0;
    logic        [13:0] i_bh = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_out_x;
    logic signed [15:0] o_out_y;
    logic        [14:0] o_out_w;
    logic        [14:0] o_out_h;
    logic               o_is_last;

    t_pair pair_queue [$];
    t_rect pending_rects [$];

    logic pair_taken = 1'b0;
    int   pairs_taken = 0;
    int   rects_checked = 0;
    int   disjoint_pairs = 0;
    int   overlap_pairs = 0;
    int   empty_pairs = 0;
    int   failures = 0;
    int   quiet_cycles = 0;
    int   hold_left = 0;
    bit   long_hold_done = 0;

    wire calm = (pairs_taken >= 250) && (pairs_taken < 320);

    rect_symmetric_difference DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_ax      (i_ax),
        .i_ay      (i_ay),
        .i_aw      (i_aw),
        .i_ah      (i_ah),
        .i_bx      (i_bx),
        .i_by      (i_by),
        .i_bw      (i_bw),
        .i_bh      (i_bh),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_out_x   (o_out_x),
        .o_out_y   (o_out_y),
        .o_out_w   (o_out_w),
        .o_out_h   (o_out_h),
        .o_is_last (o_is_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int rand_in(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic bit spans_meet(int l1, int r1, int l2, int r2);
        return ((l1 > l2) ? l1 : l2) < ((r1 < r2) ? r1 : r2);
    endfunction

    function automatic t_pair mk_pair(int ax, int ay, int aw, int ah,
                                      int bx, int by, int bw, int bh);
        t_pair p;
        p.ax = 15'(ax);
        p.ay = 15'(ay);
        p.aw = 14'(aw);
        p.ah = 14'(ah);
        p.bx = 15'(bx);
        p.by = 15'(by);
        p.bw = 14'(bw);
        p.bh = 14'(bh);
        return p;
    endfunction

    function automatic t_rect mk_rect(int x, int y, int w, int h);
        t_rect r;
        r.x    = x[rsd_pkg::CoordW-1:0];
        r.y    = y[rsd_pkg::CoordW-1:0];
        r.w    = w[rsd_pkg::SizeW-1:0];
        r.h    = h[rsd_pkg::SizeW-1:0];
        r.last = 1'b0;
        return r;
    endfunction

    // Expected rectangles for one pair go onto pending_rects.
    task automatic split_pair(input t_pair p);
        int    ax, ay, aw, ah, bx, by, bw, bh;
        int    ar, ab, br, bb;
        int    gx [4];
        int    gy [4];
        bit    in_a, in_b;
        t_rect found [$];
        ax = p.ax;
        ay = p.ay;
        aw = p.aw;
        ah = p.ah;
        bx = p.bx;
        by = p.by;
        bw = p.bw;
        bh = p.bh;
        ar = ax + aw;
        ab = ay + ah;
        br = bx + bw;
        bb = by + bh;
        if (!(spans_meet(ax, ar, bx, br) && spans_meet(ay, ab, by, bb))) begin
            found.push_back(mk_rect(ax, ay, aw, ah));
            found.push_back(mk_rect(bx, by, bw, bh));
            disjoint_pairs++;
        end else begin
            gx[0] = (ax < bx) ? ax : bx;
            gx[1] = (ax < bx) ? bx : ax;
            gx[2] = (ar < br) ? ar : br;
            gx[3] = (ar < br) ? br : ar;
            gy[0] = (ay < by) ? ay : by;
            gy[1] = (ay < by) ? by : ay;
            gy[2] = (ab < bb) ? ab : bb;
            gy[3] = (ab < bb) ? bb : ab;
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    if (gx[i+1] <= gx[i] || gy[j+1] <= gy[j]) continue;
                    in_a = spans_meet(gx[i], gx[i+1], ax, ar)
                        && spans_meet(gy[j], gy[j+1], ay, ab);
                    in_b = spans_meet(gx[i], gx[i+1], bx, br)
                        && spans_meet(gy[j], gy[j+1], by, bb);
                    if (in_a != in_b && found.size() < 8) begin
                        found.push_back(mk_rect(gx[i], gy[j],
                                                gx[i+1] - gx[i], gy[j+1] - gy[j]));
                    end
                end
            end
            overlap_pairs++;
            if (found.size() == 0) empty_pairs++;
        end
        if (found.size() > 0) found[found.size()-1].last = 1'b1;
        foreach (found[k]) pending_rects.push_back(found[k]);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    function automatic int near_edge(int pos, int a_len, int b_len);
        case ($urandom_range(3))
            0: return pos;
            1: return pos + a_len;
            2: return pos - b_len;
            default: return pos + a_len - b_len;
        endcase
    endfunction

    function automatic int pick_extreme(int lo, int hi);
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            default: return rand_in(lo, hi);
        endcase
    endfunction

    // Mostly nearby pairs that overlap or share edges; the rest extremes and noise.
    function automatic t_pair random_pair();
        int kind, ax, ay, aw, ah, bx, by, bw, bh;
        kind = $urandom_range(99);
        aw = rand_in(1, 48);
        ah = rand_in(1, 48);
        bw = rand_in(1, 48);
        bh = rand_in(1, 48);
        if ($urandom_range(9) == 0) begin
            aw = rand_in(1, 16383);
            bw = rand_in(1, 16383);
        end
        ax = rand_in(-16384, 16383);
        ay = rand_in(-16384, 16383);
        bx = ax + rand_in(-bw, aw);
        by = ay + rand_in(-bh, ah);
        if (kind >= 55 && kind < 70) begin
            bx = near_edge(ax, aw, bw);
            if ($urandom_range(1)) by = near_edge(ay, ah, bh);
        end else if (kind >= 70 && kind < 80) begin
            case ($urandom_range(3))
                0: aw = 0;
                1: ah = 0;
                2: bw = 0;
                default: bh = 0;
            endcase
        end else if (kind >= 80 && kind < 90) begin
            ax = pick_extreme(-16384, 16383);
            ay = pick_extreme(-16384, 16383);
            aw = pick_extreme(0, 16383);
            ah = pick_extreme(0, 16383);
            bx = pick_extreme(-16384, 16383);
            by = pick_extreme(-16384, 16383);
            bw = pick_extreme(0, 16383);
            bh = pick_extreme(0, 16383);
        end else if (kind >= 90) begin
            ax = $urandom;
            ay = $urandom;
            aw = $urandom;
            ah = $urandom;
            bx = $urandom;
            by = $urandom;
            bw = $urandom;
            bh = $urandom;
        end
        return mk_pair(ax, ay, aw, ah, bx, by, bw, bh);
    endfunction

    // sender
    always @(negedge i_clk) begin
        t_pair nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || pair_taken) begin
            if (pair_queue.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
                nxt = pair_queue.pop_front();
                i_ax <= nxt.ax;
                i_ay <= nxt.ay;
                i_aw <= nxt.aw;
                i_ah <= nxt.ah;
                i_bx <= nxt.bx;
                i_by <= nxt.by;
                i_bw <= nxt.bw;
                i_bh <= nxt.bh;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (!long_hold_done && pairs_taken >= 80) begin
            long_hold_done = 1;
            hold_left = HoldCycles;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 34);
        end
    end

    // monitor, predictor feed and watchdog
    always @(posedge i_clk) begin
        t_pair got;
        t_rect want;
        pair_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                got.ax = i_ax;
                got.ay = i_ay;
                got.aw = i_aw;
                got.ah = i_ah;
                got.bx = i_bx;
                got.by = i_by;
                got.bw = i_bw;
                got.bh = i_bh;
                split_pair(got);
                pairs_taken++;
            end
            if (o_valid && !i_stall) begin
                if (pending_rects.size() == 0) begin
                    $error("unexpected rectangle x=%0d y=%0d w=%0d h=%0d last=%0b",
                           o_out_x, o_out_y, o_out_w, o_out_h, o_is_last);
                    failures++;
                end else begin
                    want = pending_rects.pop_front();
                    check_field("out_x", want.x, o_out_x);
                    check_field("out_y", want.y, o_out_y);
                    check_field("out_w", want.w, o_out_w);
                    check_field("out_h", want.h, o_out_h);
                    check_field("is_last", want.last, o_is_last);
                    rects_checked++;
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QuietLimit) begin
                    $display("timeout: no word moved for %0d cycles", QuietLimit);
                    $display("[rect_symmetric_difference] ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        int directed_total;
        // identical pair: nothing out
        pair_queue.push_back(mk_pair(10, 20, 30, 40, 10, 20, 30, 40));
        // one inside the other: all eight ring cells
        pair_queue.push_back(mk_pair(0, 0, 100, 100, 30, 40, 10, 20));
        pair_queue.push_back(mk_pair(-50, -60, 5, 5, -100, -100, 200, 200));
        // corner overlap and cross
        pair_queue.push_back(mk_pair(0, 0, 20, 20, 10, 10, 20, 20));
        pair_queue.push_back(mk_pair(-30, 0, 60, 10, 0, -30, 10, 60));
        // shared edges leave zero-size grid cells
        pair_queue.push_back(mk_pair(5, 5, 20, 20, 5, 10, 10, 5));
        pair_queue.push_back(mk_pair(0, 0, 10, 10, 0, 0, 20, 10));
        pair_queue.push_back(mk_pair(10, 10, 20, 5, 0, 0, 15, 30));
        pair_queue.push_back(mk_pair(0, 0, 2, 2, 1, 1, 2, 2));
        // touching edges and corners: no overlap
        pair_queue.push_back(mk_pair(0, 0, 10, 10, 10, 0, 10, 10));
        pair_queue.push_back(mk_pair(0, 0, 10, 10, 0, 10, 10, 10));
        pair_queue.push_back(mk_pair(0, 0, 10, 10, 10, 10, 5, 5));
        // zero-size rectangles never overlap
        pair_queue.push_back(mk_pair(5, 5, 0, 10, 0, 0, 20, 20));
        pair_queue.push_back(mk_pair(0, 0, 20, 20, 5, 5, 10, 0));
        pair_queue.push_back(mk_pair(3, 3, 0, 0, 3, 3, 0, 0));
        pair_queue.push_back(mk_pair(0, 0, 0, 50, 0, 0, 0, 50));
        // field extremes
        pair_queue.push_back(mk_pair(-16384, -16384, 16383, 16383,
                                     16383, 16383, 16383, 16383));
        pair_queue.push_back(mk_pair(16383, 16383, 16383, 16383,
                                     16000, 16000, 16383, 16383));
        pair_queue.push_back(mk_pair(-16384, -16384, 16383, 16383, -100, -100, 50, 50));
        pair_queue.push_back(mk_pair(-16384, -16384, 16383, 16383,
                                     -16383, -16383, 16383, 16383));
        pair_queue.push_back(mk_pair(-16384, 16383, 1, 1, -1, -1, 1, 1));
        directed_total = pair_queue.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        wait (pairs_taken == directed_total);
        wait (pending_rects.size() == 0);

        repeat (RandomPairs) pair_queue.push_back(random_pair());
        wait (pairs_taken == directed_total + RandomPairs);
        wait (pending_rects.size() == 0);
        repeat (DrainCycles) @(posedge i_clk);

        $display("covered %0d pairs: %0d disjoint, %0d overlapping (%0d with no output)",
                 pairs_taken, disjoint_pairs, overlap_pairs, empty_pairs);
        $display("checked %0d rectangles under random stalls and one long receiver hold",
                 rects_checked);
        if (failures == 0) begin
            $display("[rect_symmetric_difference] OK");
        end else begin
            $display("[rect_symmetric_difference] ERROR");
        end
        $finish;
    end

endmodule
